>>> design/lste_pkg.sv
package lste_pkg;

    // Fixed-point formats shared by the datapath.
    localparam int COORD_FRAC_BITS = 4;
    localparam int Q14_BITS = 14;
    localparam int PIX_SHIFT = COORD_FRAC_BITS + Q14_BITS;
    localparam int WAVE_W = 15;
    localparam int PIX_W = 17;
    localparam int PIX_HI = 32767;
    localparam int PIX_LO = -32768;

    // Defaults for the top-level parameters.
    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS = 24;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ZOOM       = 3'd0,
        CFG_CAMERA_X   = 3'd1,
        CFG_CAMERA_Y   = 3'd2,
        CFG_MONO       = 3'd3,
        CFG_ABERRATION = 3'd4
    } cfg_index_t;

    // BT.601 luma weights scaled by 65536, and the halo alpha.
    localparam logic [15:0] GREY_R = 16'd19595;
    localparam logic [15:0] GREY_G = 16'd38470;
    localparam logic [15:0] GREY_B = 16'd7471;
    localparam logic [7:0] HALO_ALPHA = 8'd100;

    // Quarter turn in Q30 radians, used to build the sine table.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q14 = 64'd16384;

    typedef struct packed {
        logic [15:0]        zoom_factor;
        logic signed [23:0] camera_x;
        logic signed [23:0] camera_y;
        logic               monochrome_enable;
        logic [11:0]        aberration_offset;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        zoom_factor:       16'd4096,
        camera_x:          24'sd0,
        camera_y:          24'sd0,
        monochrome_enable: 1'b0,
        aberration_offset: 12'd0
    };

    typedef struct packed {
        logic signed [15:0] seg_x1;
        logic signed [15:0] seg_y1;
        logic signed [15:0] seg_x2;
        logic signed [15:0] seg_y2;
        logic [15:0]        rotation_angle;
        logic [15:0]        shape_scale;
        logic signed [23:0] origin_x;
        logic signed [23:0] origin_y;
        logic [31:0]        color_rgba;
        logic               last_segment;
    } seg_item_t;

    typedef struct packed {
        logic signed [15:0] line_x1;
        logic signed [15:0] line_y1;
        logic signed [15:0] line_x2;
        logic signed [15:0] line_y2;
        logic [7:0]         draw_red;
        logic [7:0]         draw_green;
        logic [7:0]         draw_blue;
        logic [7:0]         draw_alpha;
        logic               run_last;
        logic               shape_last;
    } line_cmd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    // One transformed segment: whole-pixel endpoints clamped to one below the
    // 16-bit range, so that a later +1 still saturates correctly. The x
    // coordinates come shifted left, centered and shifted right.
    typedef struct packed {
        logic signed [PIX_W-1:0] x1_l;
        logic signed [PIX_W-1:0] x1_c;
        logic signed [PIX_W-1:0] x1_r;
        logic signed [PIX_W-1:0] x2_l;
        logic signed [PIX_W-1:0] x2_c;
        logic signed [PIX_W-1:0] x2_r;
        logic signed [PIX_W-1:0] y1;
        logic signed [PIX_W-1:0] y2;
        color_t                  color;
        logic                    last_segment;
    } qent_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    // Quarter-wave sine entry k in Q1.14, from a Taylor series in Q30 rounded
    // half up. Evaluated at elaboration only.
    function automatic logic [WAVE_W-1:0] quarter_wave_value(input int unsigned k,
                                                             input int unsigned table_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x = (64'(k) * HALF_PI_Q30) >> (table_bits - 2);
        x2 = (x * x) >> 30;
        t = x;
        sum = $signed(x);
        t = ((t * x2) >> 30) / 64'd6;
        sum = sum - $signed(t);
        t = ((t * x2) >> 30) / 64'd20;
        sum = sum + $signed(t);
        t = ((t * x2) >> 30) / 64'd42;
        sum = sum - $signed(t);
        t = ((t * x2) >> 30) / 64'd72;
        sum = sum + $signed(t);
        t = ((t * x2) >> 30) / 64'd110;
        sum = sum - $signed(t);
        t = ((t * x2) >> 30) / 64'd156;
        sum = sum + $signed(t);
        t = ((t * x2) >> 30) / 64'd210;
        sum = sum - $signed(t);
        t = ((t * x2) >> 30) / 64'd272;
        sum = sum + $signed(t);
        t = ((t * x2) >> 30) / 64'd342;
        sum = sum - $signed(t);
        if (sum < 0)
        begin
            sum = '0;
        end
        q = ($unsigned(sum) + 64'd32768) >> 16;
        if (q > ONE_Q14)
        begin
            q = ONE_Q14;
        end
        return q[WAVE_W-1:0];
    endfunction

endpackage

>>> design/lste_front.sv
module lste_front #(
    parameter int SINE_TABLE_BITS = lste_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lste_pkg::cfg_t      cfg,
    input  logic                seg_valid,
    output logic                seg_ready,
    input  lste_pkg::seg_item_t seg,
    output logic                ent_valid,
    input  logic                ent_ready,
    output lste_pkg::qent_t     ent
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int AW = SINE_TABLE_BITS - 1;
    localparam int ROT_W = 32;
    localparam int MUL_W = 40;
    localparam int FIX_W = 42;
    localparam int PW = lste_pkg::PIX_W;
    localparam logic signed [FIX_W-1:0] TRUNC_BIAS =
        FIX_W'((64'd1 << lste_pkg::PIX_SHIFT) - 64'd1);
    localparam logic signed [FIX_W-1:0] CLAMP_HI = FIX_W'(lste_pkg::PIX_HI);
    localparam logic signed [FIX_W-1:0] CLAMP_LO = FIX_W'(lste_pkg::PIX_LO - 1);

    // Truncate toward zero to whole pixels and clamp to one below the 16-bit range.
    function automatic logic signed [PW-1:0] trunc_clamp(input logic signed [FIX_W-1:0] v);
        logic signed [FIX_W-1:0] biased;
        logic signed [FIX_W-1:0] t;
        biased = v + (v[FIX_W-1] ? TRUNC_BIAS : '0);
        t = biased >>> lste_pkg::PIX_SHIFT;
        if (t > CLAMP_HI)
        begin
            return PW'(CLAMP_HI);
        end
        else if (t < CLAMP_LO)
        begin
            return PW'(CLAMP_LO);
        end
        return t[PW-1:0];
    endfunction

    // Quarter-wave sine table.
    logic [lste_pkg::WAVE_W-1:0] wave [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++)
    begin : g_wave
        assign wave[k] = lste_pkg::quarter_wave_value(k, SINE_TABLE_BITS);
    end

    // Pipeline control: every stage moves when the last one can drain.
    logic f_adv;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic s6_valid_reg;

    assign f_adv = !s6_valid_reg || ent_ready;
    assign seg_ready = f_adv;
    assign ent_valid = s6_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            s1_valid_reg <= seg_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    // Stage 1: table addresses from the binary angle, with quadrant folding.
    logic [SINE_TABLE_BITS-1:0] angle_idx;
    logic [1:0]                 quad_s;
    logic [1:0]                 quad_c;
    logic [AW-1:0]              step_w;
    logic [AW-1:0]              mirror;
    logic [AW-1:0]              sin_addr;
    logic [AW-1:0]              cos_addr;

    assign angle_idx = seg.rotation_angle[15 -: SINE_TABLE_BITS];
    assign quad_s = angle_idx[SINE_TABLE_BITS-1 -: 2];
    assign quad_c = quad_s + 2'd1;
    assign step_w = {1'b0, angle_idx[SINE_TABLE_BITS-3:0]};
    assign mirror = AW'(QUARTER) - step_w;
    assign sin_addr = quad_s[0] ? mirror : step_w;
    assign cos_addr = quad_c[0] ? mirror : step_w;

    lste_pkg::seg_item_t         s1_item_reg;
    logic [lste_pkg::WAVE_W-1:0] s1_sin_mag_reg;
    logic [lste_pkg::WAVE_W-1:0] s1_cos_mag_reg;
    logic                        s1_sin_neg_reg;
    logic                        s1_cos_neg_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s1_item_reg <= seg;
            s1_sin_mag_reg <= wave[sin_addr];
            s1_cos_mag_reg <= wave[cos_addr];
            s1_sin_neg_reg <= quad_s[1];
            s1_cos_neg_reg <= quad_c[1];
        end
    end

    // Stage 2: the eight rotation products, scale times zoom, origin minus
    // camera, and the optional grey conversion.
    logic signed [15:0]       sin_val;
    logic signed [15:0]       cos_val;
    logic [23:0]              grey_sum;
    lste_pkg::color_t         color_in;
    lste_pkg::color_t         s2_color_next;

    assign sin_val = s1_sin_neg_reg ? -$signed({1'b0, s1_sin_mag_reg})
                                    : $signed({1'b0, s1_sin_mag_reg});
    assign cos_val = s1_cos_neg_reg ? -$signed({1'b0, s1_cos_mag_reg})
                                    : $signed({1'b0, s1_cos_mag_reg});
    assign color_in = s1_item_reg.color_rgba;
    assign grey_sum = lste_pkg::GREY_R * 24'(color_in.red)
                    + lste_pkg::GREY_G * 24'(color_in.green)
                    + lste_pkg::GREY_B * 24'(color_in.blue);

    always_comb
    begin
        s2_color_next = color_in;
        if (cfg.monochrome_enable)
        begin
            s2_color_next.red = grey_sum[23:16];
            s2_color_next.green = grey_sum[23:16];
            s2_color_next.blue = grey_sum[23:16];
        end
    end

    logic signed [ROT_W-1:0] s2_axc_reg, s2_ays_reg, s2_axs_reg, s2_ayc_reg;
    logic signed [ROT_W-1:0] s2_bxc_reg, s2_bys_reg, s2_bxs_reg, s2_byc_reg;
    logic [31:0]             s2_sz_reg;
    logic signed [24:0]      s2_dx_reg, s2_dy_reg;
    lste_pkg::color_t        s2_color_reg;
    logic                    s2_last_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s2_axc_reg <= s1_item_reg.seg_x1 * cos_val;
            s2_ays_reg <= s1_item_reg.seg_y1 * sin_val;
            s2_axs_reg <= s1_item_reg.seg_x1 * sin_val;
            s2_ayc_reg <= s1_item_reg.seg_y1 * cos_val;
            s2_bxc_reg <= s1_item_reg.seg_x2 * cos_val;
            s2_bys_reg <= s1_item_reg.seg_y2 * sin_val;
            s2_bxs_reg <= s1_item_reg.seg_x2 * sin_val;
            s2_byc_reg <= s1_item_reg.seg_y2 * cos_val;
            s2_sz_reg <= s1_item_reg.shape_scale * cfg.zoom_factor;
            s2_dx_reg <= 25'(s1_item_reg.origin_x) - 25'(cfg.camera_x);
            s2_dy_reg <= 25'(s1_item_reg.origin_y) - 25'(cfg.camera_y);
            s2_color_reg <= s2_color_next;
            s2_last_reg <= s1_item_reg.last_segment;
        end
    end

    // Stage 3: rotated coordinates.
    logic signed [ROT_W-1:0] s3_rx1_reg, s3_ry1_reg, s3_rx2_reg, s3_ry2_reg;
    logic [31:0]             s3_sz_reg;
    logic signed [24:0]      s3_dx_reg, s3_dy_reg;
    lste_pkg::color_t        s3_color_reg;
    logic                    s3_last_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s3_rx1_reg <= s2_axc_reg - s2_ays_reg;
            s3_ry1_reg <= s2_axs_reg + s2_ayc_reg;
            s3_rx2_reg <= s2_bxc_reg - s2_bys_reg;
            s3_ry2_reg <= s2_bxs_reg + s2_byc_reg;
            s3_sz_reg <= s2_sz_reg;
            s3_dx_reg <= s2_dx_reg;
            s3_dy_reg <= s2_dy_reg;
            s3_color_reg <= s2_color_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Stage 4: scale by shape scale times zoom, floor-shifted back by 24 bits.
    logic signed [64:0] m_x1, m_y1, m_x2, m_y2;

    assign m_x1 = s3_rx1_reg * $signed({1'b0, s3_sz_reg});
    assign m_y1 = s3_ry1_reg * $signed({1'b0, s3_sz_reg});
    assign m_x2 = s3_rx2_reg * $signed({1'b0, s3_sz_reg});
    assign m_y2 = s3_ry2_reg * $signed({1'b0, s3_sz_reg});

    logic signed [MUL_W-1:0] s4_mx1_reg, s4_my1_reg, s4_mx2_reg, s4_my2_reg;
    logic signed [24:0]      s4_dx_reg, s4_dy_reg;
    lste_pkg::color_t        s4_color_reg;
    logic                    s4_last_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s4_mx1_reg <= m_x1[63:24];
            s4_my1_reg <= m_y1[63:24];
            s4_mx2_reg <= m_x2[63:24];
            s4_my2_reg <= m_y2[63:24];
            s4_dx_reg <= s3_dx_reg;
            s4_dy_reg <= s3_dy_reg;
            s4_color_reg <= s3_color_reg;
            s4_last_reg <= s3_last_reg;
        end
    end

    // Stage 5: add the translation, and the left and right aberration copies of x.
    logic signed [FIX_W-1:0] base_x, base_y, shift_q, fx1_c, fx2_c;

    assign base_x = FIX_W'($signed({s4_dx_reg, {lste_pkg::Q14_BITS{1'b0}}}));
    assign base_y = FIX_W'($signed({s4_dy_reg, {lste_pkg::Q14_BITS{1'b0}}}));
    assign shift_q = $signed(FIX_W'({cfg.aberration_offset, {lste_pkg::Q14_BITS{1'b0}}}));
    assign fx1_c = FIX_W'(s4_mx1_reg) + base_x;
    assign fx2_c = FIX_W'(s4_mx2_reg) + base_x;

    logic signed [FIX_W-1:0] s5_fx1_l_reg, s5_fx1_c_reg, s5_fx1_r_reg;
    logic signed [FIX_W-1:0] s5_fx2_l_reg, s5_fx2_c_reg, s5_fx2_r_reg;
    logic signed [FIX_W-1:0] s5_fy1_reg, s5_fy2_reg;
    lste_pkg::color_t        s5_color_reg;
    logic                    s5_last_reg;

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s5_fx1_l_reg <= fx1_c - shift_q;
            s5_fx1_c_reg <= fx1_c;
            s5_fx1_r_reg <= fx1_c + shift_q;
            s5_fx2_l_reg <= fx2_c - shift_q;
            s5_fx2_c_reg <= fx2_c;
            s5_fx2_r_reg <= fx2_c + shift_q;
            s5_fy1_reg <= FIX_W'(s4_my1_reg) + base_y;
            s5_fy2_reg <= FIX_W'(s4_my2_reg) + base_y;
            s5_color_reg <= s4_color_reg;
            s5_last_reg <= s4_last_reg;
        end
    end

    // Stage 6: whole pixels, ready for the queue.
    lste_pkg::qent_t ent_next;
    lste_pkg::qent_t ent_reg;

    always_comb
    begin
        ent_next.x1_l = trunc_clamp(s5_fx1_l_reg);
        ent_next.x1_c = trunc_clamp(s5_fx1_c_reg);
        ent_next.x1_r = trunc_clamp(s5_fx1_r_reg);
        ent_next.x2_l = trunc_clamp(s5_fx2_l_reg);
        ent_next.x2_c = trunc_clamp(s5_fx2_c_reg);
        ent_next.x2_r = trunc_clamp(s5_fx2_r_reg);
        ent_next.y1 = trunc_clamp(s5_fy1_reg);
        ent_next.y2 = trunc_clamp(s5_fy2_reg);
        ent_next.color = s5_color_reg;
        ent_next.last_segment = s5_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            ent_reg <= ent_next;
        end
    end

    assign ent = ent_reg;

endmodule

>>> design/lste_queue.sv
module lste_queue #(
    parameter int DEPTH = lste_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  lste_pkg::qent_t push_data,
    output logic            pop_valid,
    input  logic            pop_en,
    output lste_pkg::qent_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lste_pkg::qent_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid = count_reg != '0;
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_en && pop_valid;
    assign pop_data = mem[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/lste_back.sv
module lste_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lste_pkg::cfg_t      cfg,
    input  logic                ent_valid,
    output logic                ent_pop,
    input  lste_pkg::qent_t     ent,
    output logic                line_valid,
    input  logic                line_ready,
    output lste_pkg::line_cmd_t line
);

    localparam int PW = lste_pkg::PIX_W;

    // Optional +1, then saturation to 16 bits.
    function automatic logic signed [15:0] sat_pix(input logic signed [PW-1:0] v,
                                                   input logic inc);
        logic signed [PW-1:0] s;
        s = v + $signed({{(PW-1){1'b0}}, inc});
        if (s > PW'(lste_pkg::PIX_HI))
        begin
            return 16'(lste_pkg::PIX_HI);
        end
        else if (s < PW'(lste_pkg::PIX_LO))
        begin
            return 16'(lste_pkg::PIX_LO);
        end
        return s[15:0];
    endfunction

    lste_pkg::phase_t    phase_reg, phase_next;
    logic                line_valid_reg;
    lste_pkg::line_cmd_t line_reg, line_next;
    logic                b_adv;
    logic                load;
    logic                aberr;

    assign b_adv = !line_valid_reg || line_ready;
    assign load = b_adv && ent_valid;
    assign ent_pop = load && (phase_reg == lste_pkg::PH_THIRD);
    assign aberr = cfg.aberration_offset != '0;

    // Phase sequencing: three commands per queue entry.
    always_comb
    begin
        phase_next = phase_reg;
        if (load)
        begin
            unique case (phase_reg)
                lste_pkg::PH_FIRST:  phase_next = lste_pkg::PH_SECOND;
                lste_pkg::PH_SECOND: phase_next = lste_pkg::PH_THIRD;
                lste_pkg::PH_THIRD:  phase_next = lste_pkg::PH_FIRST;
                default:             phase_next = lste_pkg::PH_FIRST;
            endcase
        end
    end

    // Command for the current phase.
    logic signed [PW-1:0] x1_raw, x2_raw;
    logic                 inc_x, inc_y;
    logic                 run_last, shape_last;
    lste_pkg::color_t     color, halo;

    always_comb
    begin
        halo.red = {1'b0, ent.color.red[7:1]};
        halo.green = {1'b0, ent.color.green[7:1]};
        halo.blue = {1'b0, ent.color.blue[7:1]};
        halo.alpha = lste_pkg::HALO_ALPHA;
        x1_raw = ent.x1_c;
        x2_raw = ent.x2_c;
        inc_x = 1'b0;
        inc_y = 1'b0;
        color = ent.color;
        run_last = 1'b0;
        shape_last = 1'b0;
        unique case (phase_reg)
            lste_pkg::PH_FIRST:
            begin
                if (aberr)
                begin
                    x1_raw = ent.x1_l;
                    x2_raw = ent.x2_l;
                    color.green = '0;
                    color.blue = '0;
                end
            end
            lste_pkg::PH_SECOND:
            begin
                if (aberr)
                begin
                    color.red = '0;
                    color.blue = '0;
                end
                else
                begin
                    inc_x = 1'b1;
                    color = halo;
                end
            end
            lste_pkg::PH_THIRD:
            begin
                run_last = 1'b1;
                shape_last = ent.last_segment;
                if (aberr)
                begin
                    x1_raw = ent.x1_r;
                    x2_raw = ent.x2_r;
                    color.red = '0;
                    color.green = '0;
                end
                else
                begin
                    inc_y = 1'b1;
                    color = halo;
                end
            end
            default:
            begin
                run_last = 1'b0;
            end
        endcase
        line_next.line_x1 = sat_pix(x1_raw, inc_x);
        line_next.line_y1 = sat_pix(ent.y1, inc_y);
        line_next.line_x2 = sat_pix(x2_raw, inc_x);
        line_next.line_y2 = sat_pix(ent.y2, inc_y);
        line_next.draw_red = color.red;
        line_next.draw_green = color.green;
        line_next.draw_blue = color.blue;
        line_next.draw_alpha = color.alpha;
        line_next.run_last = run_last;
        line_next.shape_last = shape_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lste_pkg::PH_FIRST;
            line_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (b_adv)
            begin
                line_valid_reg <= ent_valid;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            line_reg <= line_next;
        end
    end

    assign line_valid = line_valid_reg;
    assign line = line_reg;

endmodule

>>> design/line_segment_transform_emitter_unit.sv
// Line segment transform emitter. Each accepted segment request is rotated by a
// sine table, scaled by shape scale and global zoom, placed at its origin minus the
// camera, truncated to whole pixels with 16-bit saturation, and turns into three
// line commands: red, green and blue copies, red shifted left and blue right by
// the aberration offset, or, when that offset is zero, the full line followed by
// two dimmer halos moved one pixel in x and in y. A six-stage transform pipeline
// accepts one segment per cycle into a short queue unless a full queue stalls it;
// the emitter drains the queue at one command per cycle while line_ready is high,
// so the sustained rate is set by the three output commands per segment. The first
// command of a segment passes through the six pipeline stages, the queue and the
// output register. Configuration registers are written through cfg_we, cfg_index
// and cfg_data and must only change while no segment is in flight.
module line_segment_transform_emitter_unit #(
    parameter int SINE_TABLE_BITS = lste_pkg::SINE_TABLE_BITS_DEF,
    parameter int QUEUE_DEPTH = lste_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lste_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lste_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                seg_valid,
    output logic                                seg_ready,
    input  lste_pkg::seg_item_t                 seg,
    output logic                                line_valid,
    input  logic                                line_ready,
    output lste_pkg::line_cmd_t                 line
);

    // Configuration registers.
    lste_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (lste_pkg::cfg_index_t'(cfg_index))
                lste_pkg::CFG_ZOOM:       cfg_next.zoom_factor = cfg_data[15:0];
                lste_pkg::CFG_CAMERA_X:   cfg_next.camera_x = $signed(cfg_data[23:0]);
                lste_pkg::CFG_CAMERA_Y:   cfg_next.camera_y = $signed(cfg_data[23:0]);
                lste_pkg::CFG_MONO:       cfg_next.monochrome_enable = cfg_data[0];
                lste_pkg::CFG_ABERRATION: cfg_next.aberration_offset = cfg_data[11:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= lste_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Transform pipeline, queue and command emitter.
    logic            f_valid, f_ready;
    lste_pkg::qent_t f_ent;
    logic            q_valid, q_pop;
    lste_pkg::qent_t q_ent;

    lste_front #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .ent_valid (f_valid),
        .ent_ready (f_ready),
        .ent       (f_ent)
    );

    lste_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_ent),
        .pop_valid  (q_valid),
        .pop_en     (q_pop),
        .pop_data   (q_ent)
    );

    lste_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .ent_valid  (q_valid),
        .ent_pop    (q_pop),
        .ent        (q_ent),
        .line_valid (line_valid),
        .line_ready (line_ready),
        .line       (line)
    );

endmodule
